/* hdl/lcas_pkg.sv */
`timescale 1ns / 1ps

package lcas_pkg;

    // Field and register widths of the block's interface.
    localparam int CELL_ROW_W  = 12;
    localparam int CELL_COL_W  = 7;
    localparam int GRID_ROWS_W = 13;
    localparam int GRID_COLS_W = 8;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 13;
    localparam int S_TDATA_W   = 8;
    localparam int M_TDATA_W   = 24;

    localparam int DEF_MAX_COLS = 128;
    localparam int DEF_MAX_ROWS = 4096;

    // Smallest grid dimension that still has an interior cell.
    localparam int MIN_DIM = 3;

    localparam logic [GRID_ROWS_W-1:0] GRID_ROWS_RESET = 13'd128;
    localparam logic [GRID_COLS_W-1:0] GRID_COLS_RESET = 8'd128;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_GRID_ROWS = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_GRID_COLS = 1'b1;

    // What the raster stage knows about one accepted cell.
    typedef struct packed {
        logic                  cur;
        logic                  emit;
        logic                  last;
        logic [CELL_ROW_W-1:0] row;
        logic [CELL_COL_W-1:0] col;
    } cell_info_t;

endpackage

/* hdl/life_cellular_automaton_stencil_top.sv */
`timescale 1ns / 1ps

// Game of Life (B3/S23) stencil over a raster cell stream. Cells of the
// current generation enter one per clock in raster order over a grid of
// grid_rows by grid_cols cells, border included; border inputs count as dead.
// For each interior cell the next state leaves on the master side with its
// row and column, and tlast marks the last interior cell of the frame. The
// block sustains one cell per clock: both line buffers share one memory of
// MAX_COLS two-bit entries, read when a cell is accepted and written back
// when that cell leaves the first pipeline stage, so each cycle needs at most
// one read and one write.
// A window's result passes the first pipeline stage and then the output register,
// and the input is held off only while an unaccepted result waits.
// The position counters wrap after each frame; rows and columns are
// saturated to the range 3..MAX_ROWS and 3..MAX_COLS.

module life_cellular_automaton_stencil_top
    import lcas_pkg::*;
#(
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int MAX_ROWS = DEF_MAX_ROWS
) (
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,

    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [S_TDATA_W-1:0]   s_tdata,   // [0] cell_alive, [7:1] zero

    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [M_TDATA_W-1:0]   m_tdata,   // [11:0] cell_row, [18:12] cell_col,
                                              // [19] next_alive, [23:20] zero
    output logic                   m_tlast    // frame_last
);

    logic [GRID_ROWS_W-1:0] grid_rows_reg;
    logic [GRID_COLS_W-1:0] grid_cols_reg;

    logic                  advance, accept;
    logic [CELL_COL_W-1:0] col_pos;
    cell_info_t            info;
    logic                  rd_top, rd_mid;
    logic                  wr_en, wr_newer, wr_older;
    logic                  out_valid, out_alive, out_last;
    logic [CELL_ROW_W-1:0] out_row;
    logic [CELL_COL_W-1:0] out_col;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_rows_reg <= GRID_ROWS_RESET;
            grid_cols_reg <= GRID_COLS_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_GRID_ROWS: grid_rows_reg <= cfg_wdata[GRID_ROWS_W-1:0];
                REG_GRID_COLS: grid_cols_reg <= cfg_wdata[GRID_COLS_W-1:0];
                default: ;
            endcase
        end
    end

    // The whole pipeline moves whenever the output register is free or
    // being emptied in this cycle.
    assign advance  = !out_valid || m_tready;
    assign s_tready = advance;
    assign accept   = s_tvalid && advance;

    lcas_raster_ctrl #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_raster (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .cell_alive (s_tdata[0]),
        .grid_rows  (grid_rows_reg),
        .grid_cols  (grid_cols_reg),
        .col_pos    (col_pos),
        .info       (info)
    );

    lcas_line_mem #(
        .MAX_COLS (MAX_COLS)
    ) u_line_mem (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_en    (accept),
        .rd_col   (col_pos),
        .rd_top   (rd_top),
        .rd_mid   (rd_mid),
        .wr_en    (wr_en),
        .wr_newer (wr_newer),
        .wr_older (wr_older)
    );

    lcas_window u_window (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .accept    (accept),
        .info      (info),
        .rd_top    (rd_top),
        .rd_mid    (rd_mid),
        .wr_en     (wr_en),
        .wr_newer  (wr_newer),
        .wr_older  (wr_older),
        .out_valid (out_valid),
        .out_row   (out_row),
        .out_col   (out_col),
        .out_alive (out_alive),
        .out_last  (out_last)
    );

    assign m_tvalid = out_valid;
    assign m_tdata  = {4'b0000, out_alive, out_col, out_row};
    assign m_tlast  = out_last;

endmodule

/* hdl/lcas_raster_ctrl.sv */
`timescale 1ns / 1ps

module lcas_raster_ctrl
    import lcas_pkg::*;
#(
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int MAX_ROWS = DEF_MAX_ROWS
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   accept,
    input  logic                   cell_alive,
    input  logic [GRID_ROWS_W-1:0] grid_rows,
    input  logic [GRID_COLS_W-1:0] grid_cols,
    output logic [CELL_COL_W-1:0]  col_pos,
    output cell_info_t             info
);

    localparam int RLW = ($clog2(MAX_ROWS) + 1 > GRID_ROWS_W) ?
                         $clog2(MAX_ROWS) + 1 : GRID_ROWS_W;
    localparam int CLW = ($clog2(MAX_COLS) + 1 > GRID_COLS_W) ?
                         $clog2(MAX_COLS) + 1 : GRID_COLS_W;

    logic [CELL_ROW_W-1:0] row_reg, row_next;
    logic [CELL_COL_W-1:0] col_reg, col_next;

    logic [RLW-1:0] rows_ext, rows_last, row_ext;
    logic [CLW-1:0] cols_ext, cols_last, col_ext;
    logic           row_at_end, col_at_end, border;

    always_comb begin
        rows_ext = RLW'(grid_rows);
        cols_ext = CLW'(grid_cols);
        row_ext  = RLW'(row_reg);
        col_ext  = CLW'(col_reg);

        // Saturate the configured size to the range the storage supports.
        if (rows_ext < RLW'(MIN_DIM)) begin
            rows_last = RLW'(MIN_DIM - 1);
        end else if (rows_ext > RLW'(MAX_ROWS)) begin
            rows_last = RLW'(MAX_ROWS - 1);
        end else begin
            rows_last = rows_ext - RLW'(1);
        end
        if (cols_ext < CLW'(MIN_DIM)) begin
            cols_last = CLW'(MIN_DIM - 1);
        end else if (cols_ext > CLW'(MAX_COLS)) begin
            cols_last = CLW'(MAX_COLS - 1);
        end else begin
            cols_last = cols_ext - CLW'(1);
        end

        row_at_end = (row_ext >= rows_last);
        col_at_end = (col_ext >= cols_last);
        border     = (row_reg == '0) || row_at_end || (col_reg == '0) || col_at_end;

        info.cur  = cell_alive & ~border;
        // The cell at (r, c) completes the window centred on (r-1, c-1).
        info.emit = (row_ext >= RLW'(2)) && (row_ext <= rows_last) &&
                    (col_ext >= CLW'(2)) && (col_ext <= cols_last);
        info.last = (row_ext == rows_last) && (col_ext == cols_last);
        info.row  = row_reg - CELL_ROW_W'(1);
        info.col  = col_reg - CELL_COL_W'(1);

        // A position left beyond a shrunk grid wraps like the last index.
        if (col_at_end) begin
            col_next = '0;
            row_next = row_at_end ? '0 : row_reg + CELL_ROW_W'(1);
        end else begin
            col_next = col_reg + CELL_COL_W'(1);
            row_next = row_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg <= '0;
            col_reg <= '0;
        end else if (accept) begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

    assign col_pos = col_reg;

endmodule

/* hdl/lcas_line_mem.sv */
`timescale 1ns / 1ps

module lcas_line_mem
    import lcas_pkg::*;
#(
    parameter int MAX_COLS = DEF_MAX_COLS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  rd_en,
    input  logic [CELL_COL_W-1:0] rd_col,
    output logic                  rd_top,
    output logic                  rd_mid,
    input  logic                  wr_en,
    input  logic                  wr_newer,
    input  logic                  wr_older
);

    localparam int AW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int EXW = (AW + 1 > CELL_COL_W) ? AW + 1 : CELL_COL_W;

    // Each entry holds one column of both line buffers: bit 0 the older row,
    // bit 1 the newer row.
    logic [1:0] mem [MAX_COLS];

    logic [EXW-1:0] col_ext;
    logic [AW-1:0]  rd_addr;
    logic           rd_in_range;

    logic [1:0]     rd_data_reg;
    logic [AW-1:0]  addr_reg;
    logic           in_range_reg;

    assign col_ext     = EXW'(rd_col);
    assign rd_addr     = col_ext[AW-1:0];
    assign rd_in_range = (col_ext < EXW'(MAX_COLS));

    // The write-back goes to the address read one transaction earlier; the
    // column always moves between consecutive cells, so a read never meets
    // a pending write to the same entry.
    always_ff @(posedge aclk) begin
        if (wr_en && in_range_reg) begin
            mem[addr_reg] <= {wr_newer, wr_older};
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
            addr_reg    <= rd_addr;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_range_reg <= 1'b0;
        end else if (rd_en) begin
            in_range_reg <= rd_in_range;
        end
    end

    assign rd_top = rd_data_reg[0] & in_range_reg;
    assign rd_mid = rd_data_reg[1] & in_range_reg;

endmodule

/* hdl/lcas_window.sv */
`timescale 1ns / 1ps

module lcas_window
    import lcas_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  advance,
    input  logic                  accept,
    input  cell_info_t            info,
    input  logic                  rd_top,
    input  logic                  rd_mid,
    output logic                  wr_en,
    output logic                  wr_newer,
    output logic                  wr_older,
    output logic                  out_valid,
    output logic [CELL_ROW_W-1:0] out_row,
    output logic [CELL_COL_W-1:0] out_col,
    output logic                  out_alive,
    output logic                  out_last
);

    logic       s1_valid_reg;
    cell_info_t s1_info_reg;
    logic [8:0] window_reg, window_next;

    logic                  m_valid_reg;
    logic [CELL_ROW_W-1:0] m_row_reg;
    logic [CELL_COL_W-1:0] m_col_reg;
    logic                  m_alive_reg, m_last_reg;

    logic [3:0] live_total;
    logic       next_alive;

    always_comb begin
        // Bits 0..2 of each column: top, middle, bottom.
        window_next = {window_reg[5:0], s1_info_reg.cur, rd_mid, rd_top};
        live_total  = '0;
        for (int i = 0; i < 9; i++) begin
            live_total = live_total + 4'(window_next[i]);
        end
        // Counting the centre too: three live cells always give a live cell,
        // four only when the centre itself is alive.
        next_alive = (live_total == 4'd3) || (window_next[4] && (live_total == 4'd4));
    end

    assign wr_en    = advance && s1_valid_reg;
    assign wr_newer = s1_info_reg.cur;
    assign wr_older = rd_mid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            window_reg   <= '0;
            m_valid_reg  <= 1'b0;
        end else if (advance) begin
            s1_valid_reg <= accept;
            m_valid_reg  <= s1_valid_reg && s1_info_reg.emit;
            if (s1_valid_reg) begin
                window_reg <= window_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            if (accept) begin
                s1_info_reg <= info;
            end
            if (s1_valid_reg) begin
                m_row_reg   <= s1_info_reg.row;
                m_col_reg   <= s1_info_reg.col;
                m_alive_reg <= next_alive;
                m_last_reg  <= s1_info_reg.last;
            end
        end
    end

    assign out_valid = m_valid_reg;
    assign out_row   = m_row_reg;
    assign out_col   = m_col_reg;
    assign out_alive = m_alive_reg;
    assign out_last  = m_last_reg;

endmodule
